### hdl/mt4_pkg.sv
package mt4_pkg;

  localparam int unsigned Dim    = 4;
  localparam int unsigned DataW  = 32;
  localparam int unsigned ProdW  = 2 * DataW;
  localparam int unsigned AccW   = ProdW + 2;
  localparam int unsigned IdxW   = 2;

  typedef enum logic [1:0] {
    CMD_WR_A = 2'd0,
    CMD_WR_B = 2'd1,
    CMD_VEC  = 2'd2,
    CMD_MUL  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic            adv;
    logic [IdxW-1:0] k;
    logic            acc_en;
    logic            acc_first;
  } ctrl_t;

  typedef struct packed {
    logic                    en;
    logic [IdxW-1:0]         col;
    logic signed [DataW-1:0] value;
  } wr_t;

endpackage

### hdl/matrix4x4_transform_unit_core.sv
// Four multiply-accumulate lanes, one per result row, each holding its row of matrix A,
// step through the four terms of a dot product, one 32x32 multiply per lane per cycle
// while no stall holds them. A vector transform is one dot product per lane and a
// matrix product is four of them, one per column of B. A new item is taken in
// the cycle the previous one issues its last term. Each product passes through a
// product register and the accumulator before the result enters an output register. A lane
// stalls only while a finished result cannot enter a full output register.
module matrix4x4_transform_unit_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         cmd_i,
  input  logic [3:0]                         coef_index_i,
  input  logic signed [mt4_pkg::DataW-1:0]   coef_value_i,
  input  logic signed [mt4_pkg::DataW-1:0]   vec_x_i,
  input  logic signed [mt4_pkg::DataW-1:0]   vec_y_i,
  input  logic signed [mt4_pkg::DataW-1:0]   vec_z_i,
  input  logic signed [mt4_pkg::DataW-1:0]   vec_w_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mt4_pkg::DataW-1:0]   res_0_o,
  output logic signed [mt4_pkg::DataW-1:0]   res_1_o,
  output logic signed [mt4_pkg::DataW-1:0]   res_2_o,
  output logic signed [mt4_pkg::DataW-1:0]   res_3_o,
  output logic [1:0]                         column_o,
  output logic                               last_o
);

  localparam logic [mt4_pkg::DataW-1:0] One = mt4_pkg::DataW'(64'd1 << FRAC_BITS);

  logic                             accept;
  logic                             is_compute;
  logic                             stall;
  logic                             out_load;
  logic                             issue;
  logic                             issue_end;
  logic                             item_last;

  logic                             busy_q;
  logic                             vec_mode_q;
  logic [1:0]                       k_q;
  logic [1:0]                       col_q;
  logic signed [mt4_pkg::DataW-1:0] vec_q [mt4_pkg::Dim];
  logic signed [mt4_pkg::DataW-1:0] b_q [mt4_pkg::Dim * mt4_pkg::Dim];
  logic signed [mt4_pkg::DataW-1:0] operand;

  logic                             mul_valid_q;
  logic                             mul_first_q;
  logic                             mul_last_q;
  logic [1:0]                       mul_col_q;
  logic                             mul_fin_q;
  logic                             acc_done_q;
  logic [1:0]                       acc_col_q;
  logic                             acc_fin_q;

  logic                             out_valid_q;
  logic [1:0]                       column_q;
  logic                             last_q;
  logic signed [mt4_pkg::DataW-1:0] res_q [mt4_pkg::Dim];
  logic signed [mt4_pkg::DataW-1:0] lane_res [mt4_pkg::Dim];

  mt4_pkg::ctrl_t                   ctrl;
  mt4_pkg::wr_t                     lane_wr [mt4_pkg::Dim];

  assign out_load   = acc_done_q && (!out_valid_q || out_ready_i);
  assign stall      = acc_done_q && !out_load;
  assign issue      = busy_q && !stall;
  assign issue_end  = k_q == 2'd3;
  assign item_last  = issue_end && (vec_mode_q || col_q == 2'd3);
  assign in_ready_o = !busy_q || (issue && item_last);
  assign accept     = in_valid_i && in_ready_o;
  assign is_compute = cmd_i == mt4_pkg::CMD_VEC || cmd_i == mt4_pkg::CMD_MUL;

  assign operand = vec_mode_q ? vec_q[k_q] : b_q[{col_q, k_q}];

  always_comb begin
    ctrl.adv       = !stall;
    ctrl.k         = k_q;
    ctrl.acc_en    = mul_valid_q;
    ctrl.acc_first = mul_first_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      vec_mode_q <= 1'b0;
      k_q        <= '0;
      col_q      <= '0;
    end else begin
      if (issue) begin
        k_q <= k_q + 2'd1;
        if (item_last) begin
          busy_q <= 1'b0;
        end else if (issue_end) begin
          col_q <= col_q + 2'd1;
        end
      end
      if (accept && is_compute) begin
        busy_q     <= 1'b1;
        vec_mode_q <= cmd_i == mt4_pkg::CMD_VEC;
        k_q        <= '0;
        col_q      <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == mt4_pkg::CMD_VEC) begin
      vec_q[0] <= vec_x_i;
      vec_q[1] <= vec_y_i;
      vec_q[2] <= vec_z_i;
      vec_q[3] <= vec_w_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mt4_pkg::Dim * mt4_pkg::Dim; i++) begin
        b_q[i] <= ((i >> 2) == (i & 3)) ? One : '0;
      end
    end else if (accept && cmd_i == mt4_pkg::CMD_WR_B) begin
      b_q[coef_index_i] <= coef_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      mul_first_q <= 1'b0;
      mul_last_q  <= 1'b0;
      mul_col_q   <= '0;
      mul_fin_q   <= 1'b0;
      acc_done_q  <= 1'b0;
      acc_col_q   <= '0;
      acc_fin_q   <= 1'b0;
    end else if (!stall) begin
      mul_valid_q <= busy_q;
      mul_first_q <= k_q == 2'd0;
      mul_last_q  <= issue_end;
      mul_col_q   <= vec_mode_q ? 2'd0 : col_q;
      mul_fin_q   <= item_last;
      acc_done_q  <= mul_valid_q && mul_last_q;
      acc_col_q   <= mul_col_q;
      acc_fin_q   <= mul_fin_q;
    end
  end

  for (genvar r = 0; r < mt4_pkg::Dim; r++) begin : g_lane
    always_comb begin
      lane_wr[r].en    = accept && cmd_i == mt4_pkg::CMD_WR_A &&
                         coef_index_i[1:0] == 2'(r);
      lane_wr[r].col   = coef_index_i[3:2];
      lane_wr[r].value = coef_value_i;
    end

    mt4_lane #(
      .FRAC_BITS (FRAC_BITS),
      .LANE      (2'(r))
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .operand_i (operand),
      .wr_i      (lane_wr[r]),
      .res_o     (lane_res[r])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int r = 0; r < mt4_pkg::Dim; r++) begin
        res_q[r] <= lane_res[r];
      end
      column_q <= acc_col_q;
      last_q   <= acc_fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_0_o     = res_q[0];
  assign res_1_o     = res_q[1];
  assign res_2_o     = res_q[2];
  assign res_3_o     = res_q[3];
  assign column_o    = column_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  // A compute command must keep the issue sequencer busy on the next cycle.
  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_compute) |=> busy_q)
    else $error("compute transfer did not start the sequencer");

  // A finished dot product that cannot move on must be held.
  a_done_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> acc_done_q)
    else $error("finished result dropped during stall");

  // No product enters the lanes while the sequencer is idle.
  a_idle_no_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !stall) |=> !mul_valid_q)
    else $error("multiply issued while idle");

  // A transfer is never taken while a term other than the final one is pending.
  a_ready_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !item_last) |-> !in_ready_o)
    else $error("input ready in the middle of an item");
`endif

endmodule

### hdl/mt4_lane.sv
module mt4_lane #(
  parameter int unsigned FRAC_BITS = 16,
  parameter logic [1:0]  LANE      = 2'd0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mt4_pkg::ctrl_t                      ctrl_i,
  input  logic signed [mt4_pkg::DataW-1:0]    operand_i,
  input  mt4_pkg::wr_t                        wr_i,
  output logic signed [mt4_pkg::DataW-1:0]    res_o
);

  localparam logic [mt4_pkg::DataW-1:0] One = mt4_pkg::DataW'(64'd1 << FRAC_BITS);

  logic signed [mt4_pkg::DataW-1:0] a_q [mt4_pkg::Dim];
  logic signed [mt4_pkg::DataW-1:0] a_sel;
  logic signed [mt4_pkg::ProdW-1:0] prod;
  logic signed [mt4_pkg::ProdW-1:0] mul_q;
  logic signed [mt4_pkg::AccW-1:0]  acc_q;
  logic signed [mt4_pkg::AccW-1:0]  acc_d;
  logic signed [mt4_pkg::AccW-1:0]  shifted;

  // This lane owns one row of A; the register index is the column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < mt4_pkg::Dim; c++) begin
        a_q[c] <= (c == int'(LANE)) ? One : '0;
      end
    end else if (wr_i.en) begin
      a_q[wr_i.col] <= wr_i.value;
    end
  end

  assign a_sel = a_q[ctrl_i.k];
  assign prod  = a_sel * operand_i;
  assign acc_d = ctrl_i.acc_first ? mt4_pkg::AccW'(mul_q)
                                  : acc_q + mt4_pkg::AccW'(mul_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      mul_q <= prod;
      if (ctrl_i.acc_en) begin
        acc_q <= acc_d;
      end
    end
  end

  assign shifted = acc_q >>> FRAC_BITS;

  always_comb begin
    if ((&shifted[mt4_pkg::AccW-1:mt4_pkg::DataW-1]) ||
        !(|shifted[mt4_pkg::AccW-1:mt4_pkg::DataW-1])) begin
      res_o = shifted[mt4_pkg::DataW-1:0];
    end else if (shifted[mt4_pkg::AccW-1]) begin
      res_o = {1'b1, {(mt4_pkg::DataW-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(mt4_pkg::DataW-1){1'b1}}};
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import mt4_pkg::*;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ReportMax  = 10;
  localparam int unsigned PhaseItems = 112;

  typedef logic signed [DataW-1:0] word_t;
  typedef logic [Dim-1:0][DataW-1:0] quad_t;

  localparam word_t WordMax = 32'sh7fff_ffff;
  localparam word_t WordMin = 32'sh8000_0000;
  localparam word_t WordOne = 32'sh0001_0000;

  typedef struct {
    cmd_e        cmd;
    logic [3:0]  idx;
    word_t       coef;
    quad_t       vec;
    int unsigned tx_idle;
    int unsigned rx_stall;
    bit          drain;
    bit          hold_rx;
  } xfer_t;

  typedef struct packed {
    quad_t      res;
    logic [1:0] column;
    logic       last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  cmd_i;
  logic [3:0]  coef_index_i;
  word_t       coef_value_i;
  word_t       vec_x_i;
  word_t       vec_y_i;
  word_t       vec_z_i;
  word_t       vec_w_i;
  logic        out_valid_o;
  logic        out_ready_i;
  word_t       res_0_o;
  word_t       res_1_o;
  word_t       res_2_o;
  word_t       res_3_o;
  logic [1:0]  column_o;
  logic        last_o;

  word_t       mat_a [Dim*Dim];
  word_t       mat_b [Dim*Dim];
  xfer_t       cmd_fifo [$];
  result_t     due_vectors [$];
  xfer_t       offered;
  bit          offer_taken;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned rx_stall_pct;
  int unsigned stall_run;
  int unsigned n_err;
  int unsigned n_out;
  int unsigned n_cmd [4];

  matrix4x4_transform_unit_core #(
    .FRAC_BITS(FracBits)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .coef_index_i(coef_index_i),
    .coef_value_i(coef_value_i),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .vec_z_i     (vec_z_i),
    .vec_w_i     (vec_w_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_0_o     (res_0_o),
    .res_1_o     (res_1_o),
    .res_2_o     (res_2_o),
    .res_3_o     (res_3_o),
    .column_o    (column_o),
    .last_o      (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic word_t fx_dot(input quad_t row, input quad_t col);
    logic signed [ProdW-1:0] prod;
    logic signed [AccW-1:0]  sum;
    sum = '0;
    for (int k = 0; k < Dim; k++) begin
      prod = $signed(row[k]) * $signed(col[k]);
      sum  = sum + prod;
    end
    sum = sum >>> FracBits;
    if (sum[AccW-1:DataW-1] == '0 || sum[AccW-1:DataW-1] == '1) begin
      return sum[DataW-1:0];
    end
    return sum[AccW-1] ? WordMin : WordMax;
  endfunction

  task automatic exec_matrix_cmd(input xfer_t t);
    quad_t   row;
    quad_t   col;
    result_t r;
    case (t.cmd)
      CMD_WR_A: begin
        mat_a[t.idx] = t.coef;
      end
      CMD_WR_B: begin
        mat_b[t.idx] = t.coef;
      end
      CMD_VEC: begin
        for (int y = 0; y < Dim; y++) begin
          for (int c = 0; c < Dim; c++) row[c] = mat_a[Dim*c+y];
          r.res[y] = fx_dot(row, t.vec);
        end
        r.column = '0;
        r.last   = 1'b1;
        due_vectors.push_back(r);
      end
      default: begin
        for (int x = 0; x < Dim; x++) begin
          for (int c = 0; c < Dim; c++) col[c] = mat_b[Dim*x+c];
          for (int y = 0; y < Dim; y++) begin
            for (int c = 0; c < Dim; c++) row[c] = mat_a[Dim*c+y];
            r.res[y] = fx_dot(row, col);
          end
          r.column = 2'(x);
          r.last   = (x == Dim - 1);
          due_vectors.push_back(r);
        end
      end
    endcase
  endtask

  function automatic word_t rand_word();
    int v;
    case ($urandom_range(0, 11))
      0: return WordMax;
      1: return WordMin;
      2, 3, 4: return word_t'($urandom);
      default: begin
        v = int'($urandom_range(0, 32'h7ffff)) - 32'sh40000;
        return word_t'(v);
      end
    endcase
  endfunction

  function automatic xfer_t pack_cmd(input cmd_e c, input logic [3:0] i, input word_t k,
                                     input word_t x, input word_t y, input word_t z,
                                     input word_t w);
    xfer_t t;
    t.cmd      = c;
    t.idx      = i;
    t.coef     = k;
    t.vec      = {w, z, y, x};
    t.tx_idle  = 0;
    t.rx_stall = 0;
    t.drain    = 1'b0;
    t.hold_rx  = 1'b0;
    return t;
  endfunction

  task automatic queue_random(input int unsigned n, input int unsigned tx,
                              input int unsigned rx, input bit with_hold);
    xfer_t       t;
    cmd_e        c;
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      c = (pick < 25) ? CMD_WR_A : (pick < 50) ? CMD_WR_B : (pick < 80) ? CMD_VEC : CMD_MUL;
      if (with_hold && i == n / 3) c = CMD_MUL;
      t = pack_cmd(c, 4'($urandom_range(0, 15)), rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_word());
      t.tx_idle  = tx;
      t.rx_stall = rx;
      t.drain    = (i == 0);
      t.hold_rx  = with_hold && (i == n / 3);
      cmd_fifo.push_back(t);
    end
  endtask

  always @(negedge clk_i) begin : drive
    xfer_t nxt;
    bit    launch;
    launch = 1'b0;
    if (rst_ni && (!in_valid_i || offer_taken)) begin
      offer_taken = 1'b0;
      if (cmd_fifo.size() > 0) begin
        nxt    = cmd_fifo[0];
        launch = !(nxt.drain && due_vectors.size() > 0) &&
                 ($urandom_range(0, 99) >= nxt.tx_idle);
      end
      if (launch) begin
        void'(cmd_fifo.pop_front());
        offered       = nxt;
        cmd_i        <= nxt.cmd;
        coef_index_i <= nxt.idx;
        coef_value_i <= nxt.coef;
        vec_x_i      <= nxt.vec[0];
        vec_y_i      <= nxt.vec[1];
        vec_z_i      <= nxt.vec[2];
        vec_w_i      <= nxt.vec[3];
        in_valid_i   <= 1'b1;
      end else begin
        in_valid_i   <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : accept
    if (rst_ni) begin
      if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = HoldCycles;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    = hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : watch
    result_t got;
    result_t want;
    bit      moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        n_out = n_out + 1;
        got   = {res_3_o, res_2_o, res_1_o, res_0_o, column_o, last_o};
        if (due_vectors.size() == 0) begin
          n_err = n_err + 1;
          if (n_err <= ReportMax) begin
            $display("Result %0d arrived with nothing outstanding: %h %h %h %h col %0d last %0b",
                     n_out, res_0_o, res_1_o, res_2_o, res_3_o, column_o, last_o);
          end
        end else begin
          want = due_vectors.pop_front();
          if (got !== want) begin
            n_err = n_err + 1;
            if (n_err <= ReportMax) begin
              $display("Result %0d mismatch: expected %h %h %h %h col %0d last %0b",
                       n_out, want.res[0], want.res[1], want.res[2], want.res[3],
                       want.column, want.last);
              $display("  actual %h %h %h %h col %0d last %0b",
                       res_0_o, res_1_o, res_2_o, res_3_o, column_o, last_o);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        exec_matrix_cmd(offered);
        n_cmd[offered.cmd] = n_cmd[offered.cmd] + 1;
        offer_taken  = 1'b1;
        rx_stall_pct = offered.rx_stall;
        if (offered.hold_rx) hold_req = 1'b1;
      end
      stall_run = moved ? 0 : stall_run + 1;
    end
  end

  initial begin
    while (stall_run < StallLimit) @(posedge clk_i);
    $display("matrix4x4_transform_unit_core verification failed");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    out_ready_i  = 1'b0;
    cmd_i        = CMD_WR_A;
    coef_index_i = '0;
    coef_value_i = '0;
    vec_x_i      = '0;
    vec_y_i      = '0;
    vec_z_i      = '0;
    vec_w_i      = '0;
    offer_taken  = 1'b0;
    hold_req     = 1'b0;
    hold_left    = 0;
    rx_stall_pct = 0;
    stall_run    = 0;
    n_err        = 0;
    n_out        = 0;
    for (int i = 0; i < 4; i++) n_cmd[i] = 0;
    for (int i = 0; i < Dim * Dim; i++) begin
      mat_a[i] = (i % (Dim + 1) == 0) ? WordOne : '0;
      mat_b[i] = (i % (Dim + 1) == 0) ? WordOne : '0;
    end

    // Identity transforms first, then saturation and rounding toward minus infinity.
    cmd_fifo.push_back(pack_cmd(CMD_VEC, 4'd0, '0, WordMax, WordMin, '0, -32'sd1));
    cmd_fifo.push_back(pack_cmd(CMD_VEC, 4'd15, WordMax, 32'sd1, -32'sd1, WordOne,
                                32'sh1234_5678));
    cmd_fifo.push_back(pack_cmd(CMD_MUL, 4'd0, '0, '0, '0, '0, '0));
    cmd_fifo.push_back(pack_cmd(CMD_WR_A, 4'd0, WordMax, '0, '0, '0, '0));
    cmd_fifo.push_back(pack_cmd(CMD_WR_A, 4'd5, WordMin, '0, '0, '0, '0));
    cmd_fifo.push_back(pack_cmd(CMD_WR_A, 4'd10, WordMax, '0, '0, '0, '0));
    cmd_fifo.push_back(pack_cmd(CMD_WR_A, 4'd15, WordMin, '0, '0, '0, '0));
    cmd_fifo.push_back(pack_cmd(CMD_VEC, 4'd0, '0, WordMax, WordMax, WordMin, WordMin));
    cmd_fifo.push_back(pack_cmd(CMD_VEC, 4'd0, '0, -32'sd1, -32'sd1, 32'sd1, 32'sd1));
    cmd_fifo.push_back(pack_cmd(CMD_WR_B, 4'd0, WordMin, '0, '0, '0, '0));
    cmd_fifo.push_back(pack_cmd(CMD_WR_B, 4'd15, WordMax, '0, '0, '0, '0));
    cmd_fifo.push_back(pack_cmd(CMD_WR_B, 4'd3, -32'sd1, '0, '0, '0, '0));
    cmd_fifo.push_back(pack_cmd(CMD_WR_A, 4'd12, 32'sd1, '0, '0, '0, '0));
    cmd_fifo.push_back(pack_cmd(CMD_MUL, 4'd15, WordMin, WordMax, WordMax, WordMax, WordMax));
    cmd_fifo.push_back(pack_cmd(CMD_WR_A, 4'd3, 32'sh0002_0000, -32'sd1, -32'sd1, -32'sd1,
                                -32'sd1));
    cmd_fifo.push_back(pack_cmd(CMD_WR_B, 4'd12, 32'shffff_0000, WordMin, WordMin, WordMin,
                                WordMin));
    cmd_fifo.push_back(pack_cmd(CMD_MUL, 4'd0, '0, '0, '0, '0, '0));
    cmd_fifo.push_back(pack_cmd(CMD_VEC, 4'd0, '0, '0, '0, '0, '0));

    queue_random(PhaseItems, 0, 0, 1'b1);
    queue_random(PhaseItems, 80, 0, 1'b0);
    queue_random(PhaseItems, 0, 80, 1'b0);
    queue_random(PhaseItems, 31, 31, 1'b0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_fifo.size() != 0 || in_valid_i || due_vectors.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);

    $display("Covered %0d input transfers: %0d A writes, %0d B writes, %0d transforms, %0d products.",
             n_cmd[CMD_WR_A] + n_cmd[CMD_WR_B] + n_cmd[CMD_VEC] + n_cmd[CMD_MUL],
             n_cmd[CMD_WR_A], n_cmd[CMD_WR_B], n_cmd[CMD_VEC], n_cmd[CMD_MUL]);
    $display("Checked %0d result transfers under four pacing mixes; %0d mismatches.",
             n_out, n_err);
    if (n_err == 0) begin
      $display("matrix4x4_transform_unit_core verification clean");
    end else begin
      $display("matrix4x4_transform_unit_core verification failed");
    end
    $finish;
  end

endmodule
